// ===== rtl/marker_distance_moving_average_unit_macros.svh =====
// Assertion macros shared by the RTL of the marker distance averager.
// Each macro takes a label, the clock, the reset, an antecedent, a consequent and a message.
`ifndef MARKER_DISTANCE_MOVING_AVERAGE_UNIT_MACROS_SVH
`define MARKER_DISTANCE_MOVING_AVERAGE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MDMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MDMA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MDMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/mdma_pkg.sv =====
package mdma_pkg;

   localparam int ID_W   = 16;
   localparam int POS_W  = 24;
   localparam int MAG_W  = 24;
   localparam int SQ_W   = 48;
   localparam int ROOT_W = 24;
   localparam int DIST_W = 25;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   localparam logic [ID_W-1:0] TARGET_RESET = 16'd8;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_SQ_X   = 11'b00000000010,
      S_SQ_Y   = 11'b00000000100,
      S_SQ_Z   = 11'b00000001000,
      S_ACC    = 11'b00000010000,
      S_ROOT   = 11'b00000100000,
      S_SUM    = 11'b00001000000,
      S_RECIP  = 11'b00010000000,
      S_QEST   = 11'b00100000000,
      S_FIXMUL = 11'b01000000000,
      S_FIX    = 11'b10000000000
   } state_type;

   // Absolute value of a two's complement position; the most negative value
   // maps onto its unsigned magnitude.
   function automatic logic [MAG_W-1:0] pos_magnitude(input logic signed [POS_W-1:0] v);
      logic [MAG_W-1:0] raw;
      raw = MAG_W'(v);
      return v[POS_W-1] ? (~raw + MAG_W'(1)) : raw;
   endfunction

endpackage

// ===== rtl/marker_distance_moving_average_unit.sv =====
// Windowed mean of the distance of one tracked marker.
// The req_ channel carries one detected marker per item: its id and a signed
// Q8.16 position. Items whose id differs from the target id register are
// consumed and dropped with no result. For a matching item the block squares
// the three coordinates on one shared multiplier, takes the floor square root
// one bit per cycle, replaces the oldest entry of a WINDOW-deep ring and emits
// floor(sum / WINDOW) on the rsp_ channel as unsigned Q9.16.
// A matching item steps through SQ_X, SQ_Y, SQ_Z, ACC, ROOT, where it waits
// for the root unit, then SUM, RECIP, QEST, FIXMUL and FIX. req_ready is high
// only while the sequencer is idle, so no new item is taken until a matching
// item is through; a dropped item is consumed while the block stays idle.
// Reset clears the ring valid bits (unwritten entries read as zero), the
// running sum, the write slot and the output valid flag, and loads the target
// id with 8. The target id is written through csr_write_enable; the user
// must do so only while idle, as the block does not enforce it. On a
// receiver stall the result waits in the output register; the next item is
// still accepted and computed; only its last step waits for the earlier result.
`include "marker_distance_moving_average_unit_macros.svh"

module marker_distance_moving_average_unit
   import mdma_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ID_W-1:0]         req_marker_id,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DIST_W-1:0]       rsp_average_distance,
   input  logic                    csr_write_enable,
   input  logic [ID_W-1:0]         csr_write_data
);

   // The running sum holds up to WINDOW full-scale distances.
   localparam int SUM_W  = DIST_W + $clog2(WINDOW);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int OP_W   = (SUM_W > MAG_W) ? SUM_W : MAG_W;
   // floor(2^SUM_W / WINDOW): the estimate it gives is the true quotient or
   // one less, and a single correction step settles it.
   localparam longint unsigned RECIP_L = (64'd1 << SUM_W) / WINDOW;
   localparam logic [OP_W-1:0] RECIP   = OP_W'(RECIP_L);

   state_type state_ff, state_in;

   logic [ID_W-1:0]   target_ff, target_in;
   logic [MAG_W-1:0]  mag_x_ff, mag_x_in;
   logic [MAG_W-1:0]  mag_y_ff, mag_y_in;
   logic [MAG_W-1:0]  mag_z_ff, mag_z_in;
   logic [SQ_W-1:0]   acc_ff, acc_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic [DIST_W-1:0] q_ff, q_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_data_ff, rsp_data_in;
   logic [DIST_W-1:0] ring_rd_ff;

   logic [DIST_W-1:0] ring_mem [WINDOW];

   logic              accept;
   logic              ring_we;
   logic              out_free;
   logic [DIST_W-1:0] old_entry;
   logic [SUM_W-1:0]  remainder;

   logic              mul_en;
   logic [OP_W-1:0]   mul_a, mul_b;
   logic [2*OP_W-1:0] mul_prod;

   logic              sqrt_start;
   logic [SQ_W-1:0]   sqrt_radicand;
   logic              sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;

   mdma_mult #(
      .OP_W (OP_W)
   ) u_mult (
      .clock    (clock),
      .mul_en   (mul_en),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   mdma_sqrt u_sqrt (
      .clock         (clock),
      .reset         (reset),
      .sqrt_start    (sqrt_start),
      .sqrt_radicand (sqrt_radicand),
      .sqrt_done     (sqrt_done),
      .sqrt_root     (sqrt_root)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // An entry that was never written since reset counts as zero.
   assign old_entry = valid_ff[slot_ff] ? ring_rd_ff : '0;

   // Remainder left by the quotient estimate; it stays below 2 * WINDOW.
   assign remainder = sum_ff - mul_prod[SUM_W-1:0];

   always_comb begin
      state_in      = state_ff;
      target_in     = csr_write_enable ? csr_write_data : target_ff;
      mag_x_in      = mag_x_ff;
      mag_y_in      = mag_y_ff;
      mag_z_in      = mag_z_ff;
      acc_in        = acc_ff;
      dist_in       = dist_ff;
      sum_in        = sum_ff;
      slot_in       = slot_ff;
      valid_in      = valid_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ring_we       = 1'b0;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      sqrt_start    = 1'b0;
      sqrt_radicand = acc_ff + mul_prod[SQ_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_marker_id == target_ff)) begin
               mag_x_in = pos_magnitude(req_pos_x);
               mag_y_in = pos_magnitude(req_pos_y);
               mag_z_in = pos_magnitude(req_pos_z);
               state_in = S_SQ_X;
            end
         end
         S_SQ_X: begin
            mul_en   = 1'b1;
            mul_a    = OP_W'(mag_x_ff);
            mul_b    = OP_W'(mag_x_ff);
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            mul_en   = 1'b1;
            mul_a    = OP_W'(mag_y_ff);
            mul_b    = OP_W'(mag_y_ff);
            acc_in   = mul_prod[SQ_W-1:0];
            state_in = S_SQ_Z;
         end
         S_SQ_Z: begin
            mul_en   = 1'b1;
            mul_a    = OP_W'(mag_z_ff);
            mul_b    = OP_W'(mag_z_ff);
            acc_in   = acc_ff + mul_prod[SQ_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            // The last square is added on the way into the root unit.
            sqrt_start = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               dist_in  = DIST_W'(sqrt_root);
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            ring_we           = 1'b1;
            valid_in[slot_ff] = 1'b1;
            sum_in            = sum_ff - SUM_W'(old_entry) + SUM_W'(dist_ff);
            slot_in           = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0
                                                                 : slot_ff + SLOT_W'(1);
            state_in          = S_RECIP;
         end
         S_RECIP: begin
            mul_en   = 1'b1;
            mul_a    = OP_W'(sum_ff);
            mul_b    = RECIP;
            state_in = S_QEST;
         end
         S_QEST: begin
            q_in     = mul_prod[SUM_W +: DIST_W];
            state_in = S_FIXMUL;
         end
         S_FIXMUL: begin
            mul_en   = 1'b1;
            mul_a    = OP_W'(q_ff);
            mul_b    = OP_W'(WINDOW);
            state_in = S_FIX;
         end
         S_FIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (remainder >= SUM_W'(WINDOW)) ? q_ff + DIST_W'(1) : q_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= TARGET_RESET;
         sum_ff       <= '0;
         slot_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         sum_ff       <= sum_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      mag_z_ff    <= mag_z_in;
      acc_ff      <= acc_in;
      dist_ff     <= dist_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Distance ring: one write port at the current slot, registered read of
   // the same slot, which holds the entry about to be replaced.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[slot_ff] <= dist_ff;
      end
      ring_rd_ff <= ring_mem[slot_ff];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_average_distance = rsp_data_ff;

   `MDMA_ASSERT_SAME(a_slot_range, clock, reset, 1'b1, slot_ff <= SLOT_W'(WINDOW - 1), "write slot out of range")
   `MDMA_ASSERT_SAME(a_root_in_wait, clock, reset, sqrt_done, state_ff == S_ROOT, "root finished outside its wait state")
   `MDMA_ASSERT_NEXT(a_match_starts, clock, reset, accept && (req_marker_id == target_ff), state_ff == S_SQ_X, "matching item did not start")

endmodule

// ===== rtl/mdma_mult.sv =====
module mdma_mult
   import mdma_pkg::*;
#(
   parameter int OP_W = 32
) (
   input  logic              clock,
   input  logic              mul_en,
   input  logic [OP_W-1:0]   mul_a,
   input  logic [OP_W-1:0]   mul_b,
   output logic [2*OP_W-1:0] mul_prod
);

   logic [2*OP_W-1:0] prod_ff;
   logic [2*OP_W-1:0] prod_in;

   // The product only moves when the sequencer asks, so it can be read later.
   assign prod_in  = mul_en ? (mul_a * mul_b) : prod_ff;
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/mdma_sqrt.sv =====
`include "marker_distance_moving_average_unit_macros.svh"

module mdma_sqrt
   import mdma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              sqrt_start,
   input  logic [SQ_W-1:0]   sqrt_radicand,
   output logic              sqrt_done,
   output logic [ROOT_W-1:0] sqrt_root
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [ROOT_W+1:0] rem_shift;
   logic [ROOT_W+1:0] trial;

   // One result bit per cycle: bring down two radicand bits and try to
   // subtract four times the partial root plus one.
   assign rem_shift = {rem_ff[ROOT_W-1:0], rad_ff[SQ_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (sqrt_start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W);
         rad_in  = sqrt_radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sqrt_done = done_ff;
   assign sqrt_root = root_ff;

   `MDMA_ASSERT_SAME(a_start_when_free, clock, reset, sqrt_start, !busy_ff, "sqrt restarted while busy")
   `MDMA_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "sqrt done held longer than a cycle")
   `MDMA_ASSERT_SAME(a_busy_count, clock, reset, busy_ff, cnt_ff != '0, "sqrt busy with an empty count")

endmodule

// ===== sim/tb_marker_distance_moving_average_unit.sv =====
import mdma_pkg::*;

// Keeps its own copy of the distance window and the target id, and holds the
// averages that are still owed by the block, oldest first.
class mean_distance_tracker #(int DEPTH = 10);
   logic [ID_W-1:0]   target_id;
   logic [DIST_W-1:0] ring [DEPTH];
   logic [31:0]       total;
   int                slot;
   logic [DIST_W-1:0] pending_averages [$];
   int                errors;
   int                on_target;
   int                checked;

   function new();
      target_id = TARGET_RESET;
      foreach (ring[i]) ring[i] = '0;
      total = '0;
      slot = 0;
      errors = 0;
      on_target = 0;
      checked = 0;
   endfunction

   function void set_target(logic [ID_W-1:0] id);
      target_id = id;
   endfunction

   // Floor of the Euclidean length, built up one root bit at a time from the top.
   static function logic [DIST_W-1:0] marker_distance(logic signed [POS_W-1:0] x,
                                                      logic signed [POS_W-1:0] y,
                                                      logic signed [POS_W-1:0] z);
      logic signed [47:0] wx, wy, wz;
      logic [47:0]        energy;
      logic [47:0]        trial;
      logic [23:0]        root;
      wx = x;
      wy = y;
      wz = z;
      energy = 48'(wx * wx) + 48'(wy * wy) + 48'(wz * wz);
      root = '0;
      for (int b = 23; b >= 0; b--) begin
         trial = {24'd0, root | (24'd1 << b)};
         if (trial * trial <= energy) begin
            root = root | (24'd1 << b);
         end
      end
      return {1'b0, root};
   endfunction

   function void accept_marker(logic [ID_W-1:0] id, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
      logic [DIST_W-1:0] fresh_distance;
      if (id != target_id) return;
      fresh_distance = marker_distance(x, y, z);
      total = total - ring[slot] + fresh_distance;
      ring[slot] = fresh_distance;
      slot = (slot == DEPTH - 1) ? 0 : slot + 1;
      pending_averages.push_back(DIST_W'(total / DEPTH));
      on_target++;
   endfunction

   task report(string what);
      errors++;
      if (errors <= 40) begin
         $display("MISMATCH: %s", what);
      end
   endtask

   task check_average(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (pending_averages.size() == 0) begin
         report($sformatf("average %0d arrived with none outstanding", got));
      end else begin
         want = pending_averages.pop_front();
         checked++;
         if (got !== want) begin
            report($sformatf("average_distance got %0d, want %0d", got, want));
         end
      end
   endtask
endclass

module tb_marker_distance_moving_average_unit;
   localparam int WINDOW = 10;
   // Wait for a matching item to pass through the block, with margin.
   localparam int BLOCK_LATENCY = 40;
   // The slowest correct run is about 1100 items, plus the long receiver hold-off
   // and the drains between phases; this is several times that.
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER = 600;

   localparam logic signed [POS_W-1:0] POS_MAX = 24'h7FFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 24'h800000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [ID_W-1:0]         req_marker_id = '0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [DIST_W-1:0]       rsp_average_distance;
   logic                    csr_write_enable = 1'b0;
   logic [ID_W-1:0]         csr_write_data = '0;

   // Bookkeeping shared between the driver and the receiver process.
   int items_sent = 0;
   int target_settings = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit steady = 1'b0;

   mean_distance_tracker #(WINDOW) tracker;

   marker_distance_moving_average_unit #(.WINDOW(WINDOW)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_marker_id        (req_marker_id),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pos_z            (req_pos_z),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_average_distance (rsp_average_distance),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The watchdog ends a run that hangs, whether on a stuck handshake or on an
   // average that the block never delivers.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("tb_marker_distance_moving_average_unit failed");
         $finish;
      end
   end

   // Results are taken at the rising edge, where the handshake is decided.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_average(rsp_average_distance);
      end
   end

   // The receiver drops ready at random, never during the steady stretch. Once,
   // after enough items have gone in, it holds off for a long stretch so that a
   // finished average sits in the output register, the next item completes behind
   // it and the input side has to stall.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_OFF_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 9);
      end
   end

   // Offers one marker item and returns just after the falling edge that
   // follows its acceptance. Valid stays high into the next item unless the
   // sender decides to idle first.
   task send_marker(input logic [ID_W-1:0] id, input logic signed [POS_W-1:0] x,
                    input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] z);
      if (!steady && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_marker_id <= id;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_pos_z     <= z;
      do @(posedge clock); while (!req_ready);
      tracker.accept_marker(id, x, y, z);
      items_sent++;
      @(negedge clock);
   endtask

   // Waits until every owed average has come back, then lets the block settle
   // in case a dropped item is still being retired.
   task drain_block();
      req_valid <= 1'b0;
      while (tracker.pending_averages.size() != 0) @(negedge clock);
      repeat (BLOCK_LATENCY) @(negedge clock);
   endtask

   task write_target(input logic [ID_W-1:0] id);
      csr_write_enable <= 1'b1;
      csr_write_data   <= id;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_target(id);
      target_settings++;
   endtask

   // Mostly the tracked id, so that the window fills and wraps; the rest are
   // arbitrary ids or the target with one bit flipped, which must be dropped.
   function automatic logic [ID_W-1:0] random_id();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return tracker.target_id;
      if (pick < 85) return ID_W'($urandom);
      return tracker.target_id ^ (16'd1 << $urandom_range(ID_W - 1));
   endfunction

   // Positions range from centimeters to the full span, with the corner values
   // mixed in so that the largest squared sum comes up often.
   function automatic logic signed [POS_W-1:0] random_position();
      case ($urandom_range(5))
         0: return POS_W'($urandom_range(0, 2 ** 17) - 2 ** 16);
         1: return POS_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
         2: begin
            case ($urandom_range(4))
               0: return POS_MAX;
               1: return POS_MIN;
               2: return '0;
               3: return -24'sd1;
               default: return 24'sd1;
            endcase
         end
         default: return POS_W'($urandom);
      endcase
   endfunction

   task run_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_marker(random_id(), random_position(), random_position(), random_position());
      end
   endtask

   initial begin
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset target id. Zero distance, the largest
      // positive corner, the most negative corner (the largest squared sum),
      // mixed signs and unit steps come first.
      send_marker(TARGET_RESET, '0, '0, '0);
      send_marker(TARGET_RESET, POS_MAX, POS_MAX, POS_MAX);
      send_marker(TARGET_RESET, POS_MIN, POS_MIN, POS_MIN);
      send_marker(TARGET_RESET, POS_MIN, POS_MAX, '0);
      send_marker(TARGET_RESET, 24'sd1, '0, '0);
      send_marker(TARGET_RESET, -24'sd1, -24'sd1, -24'sd1);
      // Ids that are not the target produce nothing.
      send_marker(16'd9, POS_MAX, '0, '0);
      send_marker(16'd0, POS_MIN, '0, '0);
      send_marker(16'hFFFF, '0, POS_MAX, '0);
      send_marker(16'h8008, '0, '0, POS_MIN);
      // More than a full window, so the ring wraps and the oldest entries are
      // subtracted; the largest distance alternates with an exact distance of 13.
      for (int i = 0; i < 12; i++) begin
         if (i % 2 == 0) begin
            send_marker(TARGET_RESET, POS_MIN, POS_MIN, POS_MIN);
         end else begin
            send_marker(TARGET_RESET, 24'(3 << 16), 24'(-(4 << 16)), 24'(12 << 16));
         end
      end
      drain_block();

      // Random phases, each under its own target id, with the id written only
      // while the block is idle. The first one opens with a stretch where
      // neither side idles.
      write_target(16'd0);
      steady = 1'b1;
      run_random(150);
      steady = 1'b0;
      run_random(110);
      drain_block();

      write_target(16'hFFFF);
      run_random(260);
      drain_block();

      write_target(ID_W'($urandom_range(1, 65534)));
      run_random(260);
      drain_block();

      write_target(TARGET_RESET);
      run_random(320);
      drain_block();

      repeat (BLOCK_LATENCY) @(negedge clock);
      $display("Sent %0d marker items under %0d target id settings; %0d were on target.",
               items_sent, target_settings, tracker.on_target);
      $display("Checked %0d window averages, with one receiver hold-off of %0d cycles.",
               tracker.checked, HOLD_OFF_CYCLES);
      if (tracker.errors == 0) begin
         $display("tb_marker_distance_moving_average_unit passed");
      end else begin
         $display("tb_marker_distance_moving_average_unit failed");
      end
      $finish;
   end
endmodule
